// ===== hdl/spr_pkg.sv =====
// Shared constants and types for the slotted page record store.
`timescale 1ns / 1ps
package spr_pkg;

   localparam int RECORD_AREA_BYTES = 512;
   localparam int SLOT_LIMIT        = 64;
   localparam int SLOT_OVERHEAD     = 4;
   localparam int WORD_BYTES        = 8;
   localparam int AREA_ROWS         = RECORD_AREA_BYTES / WORD_BYTES;
   localparam int ROW_W             = $clog2(AREA_ROWS);
   localparam int ADDR_W            = 10;
   localparam int SLOT_W            = 6;
   localparam int COUNT_W           = 7;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_GET    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_LEN  = 3'd1,
      ST_SLOTS_FULL = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_BAD_SLOT  = 3'd4,
      ST_BUF_SMALL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_GET_LEN,
      FSM_GET_DATA
   } fsm_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] length;
   } slot_entry_type;

endpackage

// ===== hdl/slotted_page_record_store_core.sv =====
// Top level of the slotted page record store: control, directory state and result register.
`timescale 1ns / 1ps
// Channel   Ports                  Direction  Transfer
// request   req_valid/req_ready    in         one opcode word (insert runs: one word each)
// response  rsp_valid/rsp_ready    out        one status or record word
//
// Clear, delete and each insert word are handled in idle, as the request is taken.
// Get checks the slot, then reads the directory entry, then streams one word per
// cycle while the response is accepted, from the byte-lane record area (registered read).
// Reset is synchronous; it empties the page. Memories are not cleared.
// A request is taken only in idle while the response register is empty or draining;
// a stalled response holds the get stream in place.
module slotted_page_record_store_core
   import spr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [5:0]           req_slot_index,
   input  logic [9:0]           req_record_length,
   input  logic [63:0]          req_data_word,
   input  logic                 req_last_word,
   input  logic [9:0]           req_buffer_capacity,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [5:0]           rsp_slot_out,
   output logic [9:0]           rsp_record_size,
   output logic [63:0]          rsp_data_out,
   output logic                 rsp_last_out
);

   // control state
   fsm_type               state_ff, state_in;
   logic [SLOT_LIMIT-1:0] used_ff, used_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    deleted_ff, deleted_in;
   logic [ADDR_W-1:0]     free_ff, free_in;
   logic                  run_open_ff, run_open_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   status_type            run_status_ff, run_status_in;
   logic [SLOT_W-1:0]     run_slot_ff, run_slot_in;
   logic [ADDR_W-1:0]     run_addr_ff, run_addr_in;
   logic [ADDR_W-1:0]     run_rem_ff, run_rem_in;
   logic [SLOT_W-1:0]     get_slot_ff, get_slot_in;
   logic [ADDR_W-1:0]     get_cap_ff, get_cap_in;
   logic [ADDR_W-1:0]     get_len_ff, get_len_in;
   logic [ADDR_W-1:0]     get_addr_ff, get_addr_in;
   logic [ADDR_W-1:0]     get_rem_ff, get_rem_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memory ports
   logic                  area_wr_en, area_rd_en;
   logic [ADDR_W-1:0]     area_wr_addr, area_wr_rem, area_rd_addr;
   logic [63:0]           area_rd_data;
   logic                  slot_wr_en, slot_rd_en;
   slot_entry_type        slot_wr_entry, slot_rd_entry;
   logic [SLOT_W-1:0]     slot_wr_idx;

   // helpers
   logic                  req_fire, rsp_free, slot_bad;
   logic [SLOT_W-1:0]     lowest_free;
   logic [SLOT_W-1:0]     new_slot;
   status_type            chk_status, cur_status;
   logic [ADDR_W-1:0]     cur_addr, cur_rem;
   logic [SLOT_W-1:0]     cur_slot;
   logic [63:0]           byte_mask;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_record_size = rsp_size_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_last_out    = rsp_last_ff;

   // lowest cleared bit of the used map; bits at or above the count are always clear
   always_comb begin
      lowest_free = '0;
      for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            lowest_free = SLOT_W'(i);
         end
      end
   end

   assign new_slot = (deleted_ff != '0) ? lowest_free : count_ff[SLOT_W-1:0];
   assign slot_bad = !(({1'b0, req_slot_index} < count_ff) && used_ff[req_slot_index]);

   // admission checks for the first word of an insert run
   always_comb begin
      if (req_record_length == '0) begin
         chk_status = ST_ZERO_LEN;
      end else if (count_ff >= COUNT_W'(SLOT_LIMIT)) begin
         chk_status = ST_SLOTS_FULL;
      end else if ({1'b0, free_ff} < ({1'b0, req_record_length} + 11'(SLOT_OVERHEAD))) begin
         chk_status = ST_NO_SPACE;
      end else begin
         chk_status = ST_OK;
      end
   end

   assign cur_status = run_open_ff ? run_status_ff : chk_status;
   assign cur_addr   = run_open_ff ? run_addr_ff : (free_ff - req_record_length);
   assign cur_rem    = run_open_ff ? run_rem_ff : req_record_length;
   assign cur_slot   = run_open_ff ? run_slot_ff : new_slot;

   // bytes past the record end read as zero
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         byte_mask[i*8 +: 8] = (ADDR_W'(i) < get_rem_ff) ? 8'hFF : 8'h00;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire && (req_opcode == OP_GET) && !slot_bad) begin
               state_in = FSM_GET_LEN;
            end
         end
         FSM_GET_LEN: begin
            if ((get_cap_ff < slot_rd_entry.length) || (slot_rd_entry.length == '0)) begin
               state_in = FSM_IDLE;
            end else begin
               state_in = FSM_GET_DATA;
            end
         end
         FSM_GET_DATA: begin
            if (rsp_free && (get_rem_ff <= ADDR_W'(WORD_BYTES))) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in       = used_ff;
      count_in      = count_ff;
      deleted_in    = deleted_ff;
      free_in       = free_ff;
      run_open_in   = run_open_ff;
      run_status_in = run_status_ff;
      run_slot_in   = run_slot_ff;
      run_addr_in   = run_addr_ff;
      run_rem_in    = run_rem_ff;
      get_slot_in   = get_slot_ff;
      get_cap_in    = get_cap_ff;
      get_len_in    = get_len_ff;
      get_addr_in   = get_addr_ff;
      get_rem_in    = get_rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      area_wr_en    = 1'b0;
      area_wr_addr  = cur_addr;
      area_wr_rem   = cur_rem;
      area_rd_en    = 1'b0;
      area_rd_addr  = slot_rd_entry.offset;
      slot_wr_en    = 1'b0;
      slot_wr_idx   = new_slot;
      slot_wr_entry = '{offset: free_ff - req_record_length, length: req_record_length};
      slot_rd_en    = 1'b0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               if (req_opcode != OP_INSERT) begin
                  run_open_in = 1'b0;
               end
               case (req_opcode)
                  OP_CLEAR: begin
                     used_in       = '0;
                     count_in      = '0;
                     deleted_in    = '0;
                     free_in       = ADDR_W'(RECORD_AREA_BYTES);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = '0;
                     rsp_size_in   = '0;
                     rsp_data_in   = '0;
                     rsp_last_in   = 1'b1;
                  end
                  OP_INSERT: begin
                     if (!run_open_ff && (chk_status == ST_OK)) begin
                        slot_wr_en       = 1'b1;
                        used_in[new_slot] = 1'b1;
                        free_in          = free_ff - req_record_length;
                        if (deleted_ff != '0) begin
                           deleted_in = deleted_ff - 1'b1;
                        end else begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                     area_wr_en    = (cur_status == ST_OK);
                     run_status_in = cur_status;
                     run_slot_in   = cur_slot;
                     run_addr_in   = cur_addr + ADDR_W'(WORD_BYTES);
                     run_rem_in    = (cur_rem > ADDR_W'(WORD_BYTES)) ?
                                     cur_rem - ADDR_W'(WORD_BYTES) : '0;
                     run_open_in   = !req_last_word;
                     if (req_last_word) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cur_status;
                        rsp_slot_in   = (cur_status == ST_OK) ? cur_slot : '0;
                        rsp_size_in   = '0;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = req_slot_index;
                     rsp_size_in   = '0;
                     rsp_data_in   = '0;
                     rsp_last_in   = 1'b1;
                     if (slot_bad) begin
                        rsp_status_in = ST_BAD_SLOT;
                     end else begin
                        rsp_status_in = ST_OK;
                        used_in[req_slot_index] = 1'b0;
                        deleted_in = deleted_ff + 1'b1;
                     end
                  end
                  default: begin
                     // get
                     get_slot_in = req_slot_index;
                     get_cap_in  = req_buffer_capacity;
                     if (slot_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_SLOT;
                        rsp_slot_in   = req_slot_index;
                        rsp_size_in   = '0;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        slot_rd_en = 1'b1;
                     end
                  end
               endcase
            end
         end
         FSM_GET_LEN: begin
            // response register is empty here
            get_len_in = slot_rd_entry.length;
            if (get_cap_ff < slot_rd_entry.length) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_BUF_SMALL;
               rsp_slot_in   = get_slot_ff;
               rsp_size_in   = slot_rd_entry.length;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
            end else if (slot_rd_entry.length == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = get_slot_ff;
               rsp_size_in   = '0;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
            end else begin
               area_rd_en   = 1'b1;
               area_rd_addr = slot_rd_entry.offset;
               get_addr_in  = slot_rd_entry.offset + ADDR_W'(WORD_BYTES);
               get_rem_in   = slot_rd_entry.length;
            end
         end
         FSM_GET_DATA: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = get_slot_ff;
               rsp_size_in   = get_len_ff;
               rsp_data_in   = area_rd_data & byte_mask;
               rsp_last_in   = (get_rem_ff <= ADDR_W'(WORD_BYTES));
               if (get_rem_ff > ADDR_W'(WORD_BYTES)) begin
                  area_rd_en   = 1'b1;
                  area_rd_addr = get_addr_ff;
                  get_addr_in  = get_addr_ff + ADDR_W'(WORD_BYTES);
                  get_rem_in   = get_rem_ff - ADDR_W'(WORD_BYTES);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         deleted_ff   <= '0;
         free_ff      <= ADDR_W'(RECORD_AREA_BYTES);
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         deleted_ff   <= deleted_in;
         free_ff      <= free_in;
         run_open_ff  <= run_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_status_ff <= run_status_in;
      run_slot_ff   <= run_slot_in;
      run_addr_ff   <= run_addr_in;
      run_rem_ff    <= run_rem_in;
      get_slot_ff   <= get_slot_in;
      get_cap_ff    <= get_cap_in;
      get_len_ff    <= get_len_in;
      get_addr_ff   <= get_addr_in;
      get_rem_ff    <= get_rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   spr_area u_area (
      .clock   (clock),
      .wr_en   (area_wr_en),
      .wr_addr (area_wr_addr),
      .wr_rem  (area_wr_rem),
      .wr_data (req_data_word),
      .rd_en   (area_rd_en),
      .rd_addr (area_rd_addr),
      .rd_data (area_rd_data)
   );

   spr_slot_mem u_slot_mem (
      .clock    (clock),
      .wr_en    (slot_wr_en),
      .wr_slot  (slot_wr_idx),
      .wr_entry (slot_wr_entry),
      .rd_en    (slot_rd_en),
      .rd_slot  (req_slot_index),
      .rd_entry (slot_rd_entry)
   );

endmodule

// ===== hdl/spr_area.sv =====
// Record area: eight byte-lane memories, one unaligned 8-byte write or read per cycle.
`timescale 1ns / 1ps
module spr_area
   import spr_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [ADDR_W-1:0]     wr_rem,
   input  logic [63:0]           wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [63:0]           rd_data
);

   logic [7:0] lane_q [WORD_BYTES];
   logic [2:0] rd_shift_ff;

   for (genvar j = 0; j < WORD_BYTES; j++) begin : g_lane
      logic [7:0]       lane_mem [AREA_ROWS];
      logic [7:0]       lane_q_ff;
      logic [2:0]       wr_idx;
      logic [ROW_W-1:0] wr_row;
      logic [ROW_W-1:0] rd_row;
      logic             lane_we;

      always_comb begin
         // byte index within the incoming word that lands in this lane
         wr_idx  = 3'(j) - wr_addr[2:0];
         wr_row  = wr_addr[ROW_W+2:3] + ROW_W'(3'(j) < wr_addr[2:0]);
         rd_row  = rd_addr[ROW_W+2:3] + ROW_W'(3'(j) < rd_addr[2:0]);
         lane_we = wr_en && ({7'd0, wr_idx} < wr_rem);
      end

      always_ff @(posedge clock) begin
         if (lane_we) begin
            lane_mem[wr_row] <= wr_data[wr_idx*8 +: 8];
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            lane_q_ff <= lane_mem[rd_row];
         end
      end

      assign lane_q[j] = lane_q_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_shift_ff <= rd_addr[2:0];
      end
   end

   // rotate lanes back into record byte order
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         rd_data[i*8 +: 8] = lane_q[3'(i) + rd_shift_ff];
      end
   end

endmodule

// ===== hdl/spr_slot_mem.sv =====
// Slot directory memory: offset and length of each slot.
`timescale 1ns / 1ps
module spr_slot_mem
   import spr_pkg::*;
(
   input  logic            clock,
   input  logic            wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  slot_entry_type  wr_entry,
   input  logic            rd_en,
   input  logic [SLOT_W-1:0] rd_slot,
   output slot_entry_type  rd_entry
);

   slot_entry_type slot_mem [SLOT_LIMIT];
   slot_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_slot] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= slot_mem[rd_slot];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule
